/* rtl/obb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, constants and helpers for the oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
    localparam logic signed [32:0] ONE_Q28_OP = 33'sd268435456;

    // quaternion product slots
    localparam int PR_XX = 0;
    localparam int PR_YY = 1;
    localparam int PR_ZZ = 2;
    localparam int PR_XY = 3;
    localparam int PR_XZ = 4;
    localparam int PR_YZ = 5;
    localparam int PR_WX = 6;
    localparam int PR_WY = 7;
    localparam int PR_WZ = 8;

    // quaternion component order w, x, y, z
    localparam logic [1:0] QP_A [9] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
    localparam logic [1:0] QP_B [9] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_AXES,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_QUAT,
        PH_DOT,
        PH_PROJ,
        PH_FACE,
        PH_CROSS
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] u;
        logic [3:0] v;
        logic [1:0] m;
        logic       first;
        logic       last;
        logic       rpart;
    } tag_t;

    function automatic logic [1:0] next3(input logic [1:0] x);
        logic [1:0] r;
        r = (x == 2'd2) ? 2'd0 : x + 2'd1;
        return r;
    endfunction

    function automatic logic signed [32:0] abs33(input logic signed [31:0] x);
        logic signed [32:0] w;
        w = 33'(x);
        return w[32] ? -w : w;
    endfunction

    // round halves away from zero to q2.14, saturate to +-16384
    function automatic logic signed [15:0] rnd_sat14(input logic signed [35:0] v);
        logic [35:0] mag;
        logic [21:0] r;
        logic [15:0] rs;
        mag = v[35] ? 36'(-v) : 36'(v);
        r   = 22'((mag + 36'd8192) >> 14);
        if (r > 22'd16384)
        begin
            r = 22'd16384;
        end
        rs = r[15:0];
        return v[35] ? $signed(-rs) : $signed(rs);
    endfunction

endpackage

/* rtl/obb_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_mac
// Shared multiply-accumulate unit: operand register, 32x32 multiply, then a
// signed shifted accumulate. Carries a tag with every operation.
// ----------------------------------------------------------------------------
module obb_mac #(
    parameter int ACC_W = 84
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    issue_v,
    input  logic [31:0]             ma,
    input  logic [31:0]             mb,
    input  logic                    neg,
    input  obb_pkg::tag_t           tag,
    output logic                    fin_v,
    output logic signed [ACC_W-1:0] acc,
    output obb_pkg::tag_t           fin_tag,
    output logic                    busy
);
    import obb_pkg::*;

    logic        s1_v_reg, s2_v_reg, s3_v_reg;
    logic [31:0] s1_a_reg, s1_b_reg;
    logic        s1_neg_reg, s2_neg_reg;
    tag_t        s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [63:0] s2_p_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] term;

    always_comb
    begin
        term     = ACC_W'(s2_p_reg) << {s2_tag_reg.m, 5'b0};
        acc_next = (s2_tag_reg.first ? '0 : acc_reg)
                 + (s2_neg_reg ? $signed(-term) : $signed(term));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue_v;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg   <= ma;
        s1_b_reg   <= mb;
        s1_neg_reg <= neg;
        s1_tag_reg <= tag;
        s2_p_reg   <= s1_a_reg * s1_b_reg;
        s2_neg_reg <= s1_neg_reg;
        s2_tag_reg <= s1_tag_reg;
        if (s2_v_reg)
        begin
            acc_reg <= acc_next;
        end
        s3_tag_reg <= s2_tag_reg;
    end

    assign fin_v   = s3_v_reg && s3_tag_reg.last;
    assign acc     = acc_reg;
    assign fin_tag = s3_tag_reg;
    assign busy    = s1_v_reg || s2_v_reg || s3_v_reg;

endmodule

/* rtl/oriented_box_overlap_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_top
// Separating-axis overlap test of two oriented boxes.
// ----------------------------------------------------------------------------
// Each input item on the s_ channel is one box. An item with s_tuser = 0 is
// stored as the first box and gives no result.
// An item with s_tuser = 1 is tested against the stored box and gives one
// result item on the m_ channel, m_tdata[0] = 1 when the boxes overlap.
// A test runs every product through one shared 32x32 multiply-accumulate
// unit, three stages deep, under a small sequencer: 18 quaternion products,
// 27 axis dot products, 18*D projection steps, 24 face radius steps and
// 9*(4 + 2*T) cross-axis steps, with D = ceil((COORD_WIDTH+1)/32) and
// T = ceil((COORD_WIDTH+16)/32), and the unit drains after each phase.
// s_tready is low while a test runs. A finished result waits in the output
// register while m_tready is low; the next item is taken meanwhile, and a
// later result waits until the register is free.
// Reset clears the stored box to the origin with zero extents and a zero
// quaternion, which gives identity axes.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_top #(
    parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // centre_x, centre_y, centre_z, half_x, half_y, half_z,
    // rot_w, rot_x, rot_y, rot_z, zero pad
    input  logic [255:0] s_tdata,
    // second_box
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // overlap, zero pad
    output logic [7:0]   m_tdata
);
    import obb_pkg::*;

    localparam int TS_W     = COORD_WIDTH + 17;
    localparam int OPA_W    = TS_W;
    localparam int T_DIG    = (COORD_WIDTH + 16 + 31) / 32;
    localparam int D_DIG    = (COORD_WIDTH + 1 + 31) / 32;
    localparam int MAG_W    = 32 * T_DIG;
    localparam int ACC_W    = COORD_WIDTH + 52;
    localparam int CMP_W    = ACC_W + 16;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0] u_reg, u_next, k_reg_hi;
    logic [3:0] v_reg, v_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] m_reg, m_next;
    logic       sep_reg, sep_next;
    logic       out_v_reg, out_v_next;
    logic       out_bit_reg, out_bit_next;

    logic [31:0]              fc_reg [3];
    logic [30:0]              fh_reg [3];
    logic signed [15:0]       fq_reg [4];
    logic [31:0]              bc_reg [3];
    logic [30:0]              bh_reg [3];
    logic signed [15:0]       bq_reg [4];
    logic signed [31:0]       qp_reg [2][9];
    logic signed [15:0]       ax_reg [2][3][3];
    logic signed [15:0]       ax_new [2][3][3];
    logic signed [31:0]       c_reg [3][3];
    logic signed [TS_W-1:0]   ts_reg [2][3];
    logic [63:0]              r_reg;

    logic signed [15:0]          q_all [2][4];
    logic [30:0]                 half_all [2][3];
    logic signed [COORD_WIDTH:0] d_all [3];

    logic [1:0] u_lim, m_lim;
    logic [3:0] v_lim;
    logic [2:0] k_lim;
    logic       last_m, last_k, last_v, last_u;
    logic       issue_v, accept, load_first, load_b;

    logic signed [OPA_W-1:0] opa;
    logic signed [32:0]      opb;
    logic [OPA_W-1:0]        mag_a;
    logic [MAG_W-1:0]        mag_ax;
    logic [32:0]             mag_b;
    logic [31:0]             ma, mb;
    logic                    op_neg;
    tag_t                    tag;

    logic                    fin_v, mac_busy;
    logic signed [ACC_W-1:0] acc;
    tag_t                    fin_tag;
    logic [ACC_W-1:0]        acc_mag;
    logic [TS_W-1:0]         ts_mag;
    logic [CMP_W-1:0]        cmp_l, cmp_r;

    assign k_reg_hi = k_reg[1:0];

    always_comb
    begin
        logic [COORD_WIDTH-1:0] ca, cb;
        for (int n = 0; n < 4; n++)
        begin
            q_all[0][n] = fq_reg[n];
            q_all[1][n] = bq_reg[n];
        end
        for (int n = 0; n < 3; n++)
        begin
            half_all[0][n] = fh_reg[n];
            half_all[1][n] = bh_reg[n];
        end
        for (int n = 0; n < 3; n++)
        begin
            ca = COORD_WIDTH'(fc_reg[n]);
            cb = COORD_WIDTH'(bc_reg[n]);
            d_all[n] = $signed({ca[COORD_WIDTH-1], ca}) - $signed({cb[COORD_WIDTH-1], cb});
        end
    end

    // axes from quaternion products
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            ax_new[b][0][0] = rnd_sat14(ONE_Q28 - ((36'(qp_reg[b][PR_YY])
                              + 36'(qp_reg[b][PR_ZZ])) <<< 1));
            ax_new[b][0][1] = rnd_sat14((36'(qp_reg[b][PR_XY]) + 36'(qp_reg[b][PR_WZ])) <<< 1);
            ax_new[b][0][2] = rnd_sat14((36'(qp_reg[b][PR_XZ]) - 36'(qp_reg[b][PR_WY])) <<< 1);
            ax_new[b][1][0] = rnd_sat14((36'(qp_reg[b][PR_XY]) - 36'(qp_reg[b][PR_WZ])) <<< 1);
            ax_new[b][1][1] = rnd_sat14(ONE_Q28 - ((36'(qp_reg[b][PR_XX])
                              + 36'(qp_reg[b][PR_ZZ])) <<< 1));
            ax_new[b][1][2] = rnd_sat14((36'(qp_reg[b][PR_YZ]) + 36'(qp_reg[b][PR_WX])) <<< 1);
            ax_new[b][2][0] = rnd_sat14((36'(qp_reg[b][PR_XZ]) + 36'(qp_reg[b][PR_WY])) <<< 1);
            ax_new[b][2][1] = rnd_sat14((36'(qp_reg[b][PR_YZ]) - 36'(qp_reg[b][PR_WX])) <<< 1);
            ax_new[b][2][2] = rnd_sat14(ONE_Q28 - ((36'(qp_reg[b][PR_XX])
                              + 36'(qp_reg[b][PR_YY])) <<< 1));
        end
    end

    // loop bounds of the current phase
    always_comb
    begin
        u_lim = 2'd2;
        v_lim = 4'd3;
        k_lim = 3'd1;
        m_lim = 2'd1;
        unique case (phase_reg)
            PH_QUAT:
            begin
                v_lim = 4'd9;
            end
            PH_DOT:
            begin
                u_lim = 2'd3;
                k_lim = 3'd3;
            end
            PH_PROJ:
            begin
                k_lim = 3'd3;
                m_lim = 2'(D_DIG);
            end
            PH_FACE:
            begin
                k_lim = 3'd4;
            end
            PH_CROSS:
            begin
                u_lim = 2'd3;
                k_lim = 3'd6;
                m_lim = (k_reg >= 3'd4) ? 2'(T_DIG) : 2'd1;
            end
            default:
            begin
                u_lim = 2'd2;
            end
        endcase
        last_m = (m_reg == m_lim - 2'd1);
        last_k = (k_reg == k_lim - 3'd1);
        last_v = (v_reg == v_lim - 4'd1);
        last_u = (u_reg == u_lim - 2'd1);
    end

    // operand selection for the shared unit
    always_comb
    begin
        logic [1:0] uu, vv, i1, i2, j1, j2, jj;
        uu  = u_reg;
        vv  = v_reg[1:0];
        i1  = next3(uu);
        i2  = next3(i1);
        j1  = next3(vv);
        j2  = next3(j1);
        jj  = k_reg_hi - 2'd1;
        opa = '0;
        opb = '0;
        unique case (phase_reg)
            PH_QUAT:
            begin
                opa = OPA_W'(q_all[uu[0]][QP_A[v_reg]]);
                opb = 33'(q_all[uu[0]][QP_B[v_reg]]);
            end
            PH_DOT:
            begin
                opa = OPA_W'(ax_reg[0][uu][k_reg_hi]);
                opb = 33'(ax_reg[1][vv][k_reg_hi]);
            end
            PH_PROJ:
            begin
                opa = OPA_W'(d_all[k_reg_hi]);
                opb = 33'(ax_reg[uu[0]][vv][k_reg_hi]);
            end
            PH_FACE:
            begin
                if (k_reg == 3'd0)
                begin
                    opa = OPA_W'($signed({1'b0, half_all[uu[0]][vv]}));
                    opb = ONE_Q28_OP;
                end
                else
                begin
                    opa = OPA_W'($signed({1'b0, half_all[~uu[0]][jj]}));
                    opb = uu[0] ? abs33(c_reg[jj][vv]) : abs33(c_reg[vv][jj]);
                end
            end
            PH_CROSS:
            begin
                unique case (k_reg)
                    3'd0:
                    begin
                        opa = OPA_W'($signed({1'b0, half_all[0][i1]}));
                        opb = abs33(c_reg[i2][vv]);
                    end
                    3'd1:
                    begin
                        opa = OPA_W'($signed({1'b0, half_all[0][i2]}));
                        opb = abs33(c_reg[i1][vv]);
                    end
                    3'd2:
                    begin
                        opa = OPA_W'($signed({1'b0, half_all[1][j1]}));
                        opb = abs33(c_reg[uu][j2]);
                    end
                    3'd3:
                    begin
                        opa = OPA_W'($signed({1'b0, half_all[1][j2]}));
                        opb = abs33(c_reg[uu][j1]);
                    end
                    3'd4:
                    begin
                        opa = ts_reg[0][i2];
                        opb = 33'(c_reg[i1][vv]);
                    end
                    default:
                    begin
                        opa = ts_reg[0][i1];
                        opb = -33'(c_reg[i2][vv]);
                    end
                endcase
            end
            default:
            begin
                opa = '0;
            end
        endcase
        mag_a  = opa[OPA_W-1] ? OPA_W'(-opa) : OPA_W'(opa);
        mag_ax = MAG_W'(mag_a);
        mag_b  = opb[32] ? 33'(-opb) : 33'(opb);
        ma     = mag_ax[32*m_reg +: 32];
        mb     = mag_b[31:0];
        op_neg = opa[OPA_W-1] ^ opb[32];

        tag.phase = phase_reg;
        tag.u     = u_reg;
        tag.v     = v_reg;
        tag.m     = m_reg;
        tag.first = (m_reg == 2'd0)
                 && ((k_reg == 3'd0) || ((phase_reg == PH_CROSS) && (k_reg == 3'd4)));
        tag.last  = last_m && (last_k || ((phase_reg == PH_CROSS) && (k_reg == 3'd3)));
        tag.rpart = (phase_reg == PH_CROSS) && (k_reg < 3'd4);
    end

    obb_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue_v (issue_v),
        .ma      (ma),
        .mb      (mb),
        .neg     (op_neg),
        .tag     (tag),
        .fin_v   (fin_v),
        .acc     (acc),
        .fin_tag (fin_tag),
        .busy    (mac_busy)
    );

    // result compares
    always_comb
    begin
        logic signed [TS_W-1:0] tsv;
        tsv     = ts_reg[fin_tag.u[0]][fin_tag.v[1:0]];
        ts_mag  = tsv[TS_W-1] ? TS_W'(-tsv) : TS_W'(tsv);
        acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        if (fin_tag.phase == PH_FACE)
        begin
            cmp_l = CMP_W'(ts_mag) << 14;
            cmp_r = CMP_W'(acc_mag);
        end
        else
        begin
            cmp_l = CMP_W'(acc_mag);
            cmp_r = CMP_W'(r_reg) << 14;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        m_next       = m_reg;
        sep_next     = sep_reg;
        out_v_next   = out_v_reg && !m_tready;
        out_bit_next = out_bit_reg;
        issue_v      = 1'b0;
        s_tready     = (state_reg == ST_IDLE);
        accept       = s_tvalid && s_tready;
        load_first   = accept && !s_tuser;
        load_b       = accept && s_tuser;

        if (fin_v && !fin_tag.rpart
            && ((fin_tag.phase == PH_FACE) || (fin_tag.phase == PH_CROSS))
            && (cmp_l > cmp_r))
        begin
            sep_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_b)
                begin
                    state_next = ST_ISSUE;
                    phase_next = PH_QUAT;
                    sep_next   = 1'b0;
                    u_next     = '0;
                    v_next     = '0;
                    k_next     = '0;
                    m_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                issue_v = 1'b1;
                if (!last_m)
                begin
                    m_next = m_reg + 2'd1;
                end
                else
                begin
                    m_next = '0;
                    if (!last_k)
                    begin
                        k_next = k_reg + 3'd1;
                    end
                    else
                    begin
                        k_next = '0;
                        if (!last_v)
                        begin
                            v_next = v_reg + 4'd1;
                        end
                        else
                        begin
                            v_next = '0;
                            if (!last_u)
                            begin
                                u_next = u_reg + 2'd1;
                            end
                            else
                            begin
                                u_next     = '0;
                                state_next = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    unique case (phase_reg)
                        PH_QUAT:
                        begin
                            state_next = ST_AXES;
                        end
                        PH_DOT:
                        begin
                            state_next = ST_ISSUE;
                            phase_next = PH_PROJ;
                        end
                        PH_PROJ:
                        begin
                            state_next = ST_ISSUE;
                            phase_next = PH_FACE;
                        end
                        PH_FACE:
                        begin
                            state_next = ST_ISSUE;
                            phase_next = PH_CROSS;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_AXES:
            begin
                state_next = ST_ISSUE;
                phase_next = PH_DOT;
            end
            ST_OUT:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_v_next   = 1'b1;
                    out_bit_next = !sep_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_QUAT;
            u_reg       <= '0;
            v_reg       <= '0;
            k_reg       <= '0;
            m_reg       <= '0;
            sep_reg     <= 1'b0;
            out_v_reg   <= 1'b0;
            out_bit_reg <= 1'b0;
            for (int n = 0; n < 3; n++)
            begin
                fc_reg[n] <= '0;
                fh_reg[n] <= '0;
            end
            for (int n = 0; n < 4; n++)
            begin
                fq_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            u_reg       <= u_next;
            v_reg       <= v_next;
            k_reg       <= k_next;
            m_reg       <= m_next;
            sep_reg     <= sep_next;
            out_v_reg   <= out_v_next;
            out_bit_reg <= out_bit_next;
            if (load_first)
            begin
                fc_reg[0] <= s_tdata[31:0];
                fc_reg[1] <= s_tdata[63:32];
                fc_reg[2] <= s_tdata[95:64];
                fh_reg[0] <= s_tdata[126:96];
                fh_reg[1] <= s_tdata[157:127];
                fh_reg[2] <= s_tdata[188:158];
                fq_reg[0] <= s_tdata[204:189];
                fq_reg[1] <= s_tdata[220:205];
                fq_reg[2] <= s_tdata[236:221];
                fq_reg[3] <= s_tdata[252:237];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            bc_reg[0] <= s_tdata[31:0];
            bc_reg[1] <= s_tdata[63:32];
            bc_reg[2] <= s_tdata[95:64];
            bh_reg[0] <= s_tdata[126:96];
            bh_reg[1] <= s_tdata[157:127];
            bh_reg[2] <= s_tdata[188:158];
            bq_reg[0] <= s_tdata[204:189];
            bq_reg[1] <= s_tdata[220:205];
            bq_reg[2] <= s_tdata[236:221];
            bq_reg[3] <= s_tdata[252:237];
        end
        if (state_reg == ST_AXES)
        begin
            ax_reg <= ax_new;
        end
        if (fin_v)
        begin
            unique case (fin_tag.phase)
                PH_QUAT:
                begin
                    qp_reg[fin_tag.u[0]][fin_tag.v] <= acc[31:0];
                end
                PH_DOT:
                begin
                    c_reg[fin_tag.u][fin_tag.v[1:0]] <= acc[31:0];
                end
                PH_PROJ:
                begin
                    ts_reg[fin_tag.u[0]][fin_tag.v[1:0]] <= acc[TS_W-1:0];
                end
                PH_CROSS:
                begin
                    if (fin_tag.rpart)
                    begin
                        r_reg <= acc[63:0];
                    end
                end
                default:
                begin
                    r_reg <= r_reg;
                end
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'b0, out_bit_reg};

    // no item taken while the shared unit still has work in flight
    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mac_busy)
        else $error("input ready while the shared unit is busy");

    // the shared unit only gets work from the issue state
    a_issue_state: assert property (@(posedge clk) disable iff (!rst_n)
        issue_v |-> (state_reg == ST_ISSUE))
        else $error("operation issued outside the issue state");

    // a new result only comes out of the final state of a test
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_next && !(out_v_reg && !m_tready)) |-> (state_reg == ST_OUT))
        else $error("result loaded outside the output state");

    // the separation flag is raised only by a finished compare
    a_sep_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sep_reg) |-> $past(fin_v && ((fin_tag.phase == PH_FACE)
                                         || (fin_tag.phase == PH_CROSS))))
        else $error("separation flag set without a compare");

endmodule
